FILE: rtl/core/uvs_pkg.sv
// Shared types, constants and helper function of the UV sphere vertex generator.
package uvs_pkg;

	localparam int DIV_BITS = 40;
	localparam int ATAN_ENTRIES = 24;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	localparam logic [0:0] REG_GRID_UNITS = 1'b0;
	localparam logic [0:0] REG_RADIUS = 1'b1;

	localparam logic [31:0] ATAN_TURN [ATAN_ENTRIES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	typedef struct packed {
		logic        vld;
		logic [7:0]  ring;
		logic [7:0]  sector;
		logic [7:0]  last;
		logic [7:0]  half;
		logic [7:0]  rlon;
		logic [7:0]  rlat;
		logic [39:0] qlon;
		logic [39:0] qlat;
		logic [16:0] tex_u;
		logic [16:0] tex_v;
	} div_t;

	typedef struct packed {
		logic               vld;
		logic [7:0]         ring;
		logic [7:0]         sector;
		logic [7:0]         last;
		logic [16:0]        tex_u;
		logic [16:0]        tex_v;
		quad_t              qdlat;
		quad_t              qdlon;
		logic signed [33:0] xlat;
		logic signed [33:0] ylat;
		logic signed [32:0] zlat;
		logic signed [33:0] xlon;
		logic signed [33:0] ylon;
		logic signed [32:0] zlon;
	} cor_t;

	typedef struct packed {
		logic [16:0] tex_u;
		logic [16:0] tex_v;
		logic [15:0] qa;
		logic [15:0] qb;
		logic [15:0] qc;
		logic [15:0] qd;
	} side_t;

	// Bit of the dividend {idx, SH zero bits} + hv at bit position pos.
	function automatic logic num_bit(logic [7:0] idx, logic [7:0] hv, int pos, int sh);
		logic b;
		b = 1'b0;
		if (pos >= sh && pos - sh < 8) begin
			b = idx[pos - sh];
		end else if (pos < 8) begin
			b = hv[pos];
		end
		return b;
	endfunction

endpackage

FILE: rtl/core/uvs_div_cell.sv
// One bit cell of the restoring divider chain that forms the angle phases.
module uvs_div_cell
	import uvs_pkg::*;
#(
	parameter int POS = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  div_t d_i,
	output div_t d_o
);

	div_t       n;
	logic       blon;
	logic       blat;
	logic [8:0] r2lon;
	logic [8:0] r2lat;
	logic       gelon;
	logic       gelat;
	div_t       cell_q;

	always_comb begin
		n = d_i;
		blon = num_bit(d_i.sector, d_i.half, POS, 32);
		blat = num_bit(d_i.ring, d_i.half, POS, 31);
		r2lon = {d_i.rlon, blon};
		r2lat = {d_i.rlat, blat};
		gelon = r2lon >= {1'b0, d_i.last};
		gelat = r2lat >= {1'b0, d_i.last};
		n.rlon = gelon ? 8'(r2lon - {1'b0, d_i.last}) : r2lon[7:0];
		n.rlat = gelat ? 8'(r2lat - {1'b0, d_i.last}) : r2lat[7:0];
		n.qlon = {d_i.qlon[38:0], gelon};
		n.qlat = {d_i.qlat[38:0], gelat};
		if (POS == 16) begin
			n.tex_u = n.qlon[16:0]
				+ {16'd0, (({1'b0, n.rlon} + {1'b0, d_i.half}) >= {1'b0, d_i.last})};
		end
		if (POS == 15) begin
			n.tex_v = n.qlat[16:0]
				+ {16'd0, (({1'b0, n.rlat} + {1'b0, d_i.half}) >= {1'b0, d_i.last})};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (en) begin
			cell_q <= n;
		end
	end

	assign d_o = cell_q;

`ifndef SYNTH
	a_rem_lon: assert property (@(posedge clk) disable iff (!arst_n)
		cell_q.vld |-> cell_q.rlon < cell_q.last)
		else $error("Longitude remainder not below divisor.");
	a_rem_lat: assert property (@(posedge clk) disable iff (!arst_n)
		cell_q.vld |-> cell_q.rlat < cell_q.last)
		else $error("Latitude remainder not below divisor.");
	a_idx_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cell_q.vld |-> cell_q.ring <= cell_q.last && cell_q.sector <= cell_q.last)
		else $error("Grid index above the last index.");
`endif

endmodule

FILE: rtl/core/uvs_cordic_cell.sv
// One rotation cell of the sine and cosine chain, working both angles at once.
module uvs_cordic_cell
	import uvs_pkg::*;
#(
	parameter int K = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  cor_t c_i,
	output cor_t c_o
);

	localparam logic signed [32:0] ATAN = $signed({1'b0, ATAN_TURN[K]});

	cor_t               n;
	logic signed [33:0] dxlat;
	logic signed [33:0] dylat;
	logic signed [33:0] dxlon;
	logic signed [33:0] dylon;
	cor_t               cell_q;

	always_comb begin
		n = c_i;
		dxlat = c_i.ylat >>> K;
		dylat = c_i.xlat >>> K;
		dxlon = c_i.ylon >>> K;
		dylon = c_i.xlon >>> K;
		if (!c_i.zlat[32]) begin
			n.xlat = c_i.xlat - dxlat;
			n.ylat = c_i.ylat + dylat;
			n.zlat = c_i.zlat - ATAN;
		end else begin
			n.xlat = c_i.xlat + dxlat;
			n.ylat = c_i.ylat - dylat;
			n.zlat = c_i.zlat + ATAN;
		end
		if (!c_i.zlon[32]) begin
			n.xlon = c_i.xlon - dxlon;
			n.ylon = c_i.ylon + dylon;
			n.zlon = c_i.zlon - ATAN;
		end else begin
			n.xlon = c_i.xlon + dxlon;
			n.ylon = c_i.ylon - dylon;
			n.zlon = c_i.zlon + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (en) begin
			cell_q <= n;
		end
	end

	assign c_o = cell_q;

endmodule

FILE: rtl/core/uvs_out_stage.sv
// Output pipeline: quadrant fold, quad corner indices, normal products, radius scaling and rounding.
module uvs_out_stage
	import uvs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  cor_t         c_i,
	input  logic [15:0]  radius,
	output logic         vld_o,
	output logic [223:0] data_o
);

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	side_t              side_s1, side_s2, side_s3, side_s4, side_s5;
	logic signed [31:0] slat_s1, clat_s1, slon_s1, clon_s1;
	logic signed [63:0] px_s2, pz_s2;
	logic signed [32:0] ny_s2;
	logic signed [32:0] nx_s3, ny_s3, nz_s3;
	logic signed [49:0] ppx_s4, ppy_s4, ppz_s4;
	logic [15:0]        nmx_s4, nmy_s4, nmz_s4;
	logic [15:0]        nmx_s5, nmy_s5, nmz_s5;
	logic [23:0]        psx_s5, psy_s5, psz_s5;

	logic signed [33:0] clat, slat, clon, slon;
	side_t              side_n;
	logic [8:0]         units;
	logic [17:0]        base;
	logic [17:0]        base_nx;

	function automatic logic [15:0] norm14(logic signed [32:0] v);
		logic signed [32:0] t;
		t = (v + 33'sd32768) >>> 16;
		if (t > 33'sd16384) begin
			t = 33'sd16384;
		end else if (t < -33'sd16384) begin
			t = -33'sd16384;
		end
		return t[15:0];
	endfunction

	function automatic logic [23:0] pos14(logic signed [49:0] p);
		logic signed [49:0] t;
		t = (p + 50'sd8388608) >>> 24;
		if (t > 50'sd8388607) begin
			t = 50'sd8388607;
		end else if (t < -50'sd8388608) begin
			t = -50'sd8388608;
		end
		return t[23:0];
	endfunction

	always_comb begin
		case (c_i.qdlat)
			QUAD_0: begin clat = c_i.xlat; slat = c_i.ylat; end
			QUAD_1: begin clat = -c_i.ylat; slat = c_i.xlat; end
			QUAD_2: begin clat = -c_i.xlat; slat = -c_i.ylat; end
			QUAD_3: begin clat = c_i.ylat; slat = -c_i.xlat; end
			default: begin clat = c_i.xlat; slat = c_i.ylat; end
		endcase
		case (c_i.qdlon)
			QUAD_0: begin clon = c_i.xlon; slon = c_i.ylon; end
			QUAD_1: begin clon = -c_i.ylon; slon = c_i.xlon; end
			QUAD_2: begin clon = -c_i.xlon; slon = -c_i.ylon; end
			QUAD_3: begin clon = c_i.ylon; slon = -c_i.xlon; end
			default: begin clon = c_i.xlon; slon = c_i.ylon; end
		endcase
		units = {1'b0, c_i.last} + 9'd1;
		base = ({10'd0, c_i.ring} * {9'd0, units}) + {10'd0, c_i.sector};
		base_nx = base + {9'd0, units};
		side_n.tex_u = c_i.tex_u;
		side_n.tex_v = c_i.tex_v;
		if (c_i.ring == c_i.last || c_i.sector == c_i.last) begin
			side_n.qa = '0;
			side_n.qb = '0;
			side_n.qc = '0;
			side_n.qd = '0;
		end else begin
			side_n.qa = base[15:0];
			side_n.qb = 16'(base + 18'd1);
			side_n.qc = 16'(base_nx + 18'd1);
			side_n.qd = base_nx[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= c_i.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_n;
			slat_s1 <= slat[31:0];
			clat_s1 <= clat[31:0];
			slon_s1 <= slon[31:0];
			clon_s1 <= clon[31:0];
			side_s2 <= side_s1;
			px_s2 <= 64'(clon_s1) * 64'(slat_s1);
			pz_s2 <= 64'(slon_s1) * 64'(slat_s1);
			ny_s2 <= -33'(clat_s1);
			side_s3 <= side_s2;
			nx_s3 <= 33'((px_s2 + 64'sd536870912) >>> 30);
			nz_s3 <= 33'((pz_s2 + 64'sd536870912) >>> 30);
			ny_s3 <= ny_s2;
			side_s4 <= side_s3;
			ppx_s4 <= 50'(nx_s3) * 50'($signed({1'b0, radius}));
			ppy_s4 <= 50'(ny_s3) * 50'($signed({1'b0, radius}));
			ppz_s4 <= 50'(nz_s3) * 50'($signed({1'b0, radius}));
			nmx_s4 <= norm14(nx_s3);
			nmy_s4 <= norm14(ny_s3);
			nmz_s4 <= norm14(nz_s3);
			side_s5 <= side_s4;
			psx_s5 <= pos14(ppx_s4);
			psy_s5 <= pos14(ppy_s4);
			psz_s5 <= pos14(ppz_s4);
			nmx_s5 <= nmx_s4;
			nmy_s5 <= nmy_s4;
			nmz_s5 <= nmz_s4;
		end
	end

	assign vld_o = vld_s5;
	assign data_o = {6'd0, side_s5.qd, side_s5.qc, side_s5.qb, side_s5.qa,
		side_s5.tex_v, side_s5.tex_u, nmz_s5, nmy_s5, nmx_s5, psz_s5, psy_s5, psx_s5};

endmodule

FILE: rtl/core/uv_sphere_vertex_generator_core.sv
// Top level of the UV sphere vertex generator: input stage, cell chains and output.
//
// Each item is one grid point (ring, sector) and yields one vertex: position, unit normal,
// texture coordinates and quad corner indices. The block takes one item per clock and
// returns results in order through one input register, a chain
// of 40 one-bit divider cells that forms the angle phases and texture coordinates, one
// rotation cell per CORDIC stage, and five output stages for the products and rounding.
// When the output item is not taken, the whole chain holds.
module uv_sphere_vertex_generator_core
	import uvs_pkg::*;
#(
	parameter int MAX_UNITS = 256,
	parameter int CORDIC_STAGES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [15:0]  s_axis_tdata,  // ring_index, sector_index
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [223:0] m_axis_tdata,  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
	                                    // tex_u, tex_v, quad_a, quad_b, quad_c, quad_d
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	logic [8:0]  grid_units_q;
	logic [15:0] radius_q;
	logic        en;
	logic [8:0]  units;
	logic [7:0]  last;
	div_t        div_in;
	div_t        div_chain [DIV_BITS + 1];
	cor_t        cor_chain [CORDIC_STAGES + 1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_units_q <= 9'd16;
			radius_q <= 16'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GRID_UNITS: grid_units_q <= cfg_data[8:0];
				REG_RADIUS: radius_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_comb begin
		units = grid_units_q;
		if (units < 9'd2) begin
			units = 9'd2;
		end else if (units > 9'(MAX_UNITS)) begin
			units = 9'(MAX_UNITS);
		end
		last = 8'(units - 9'd1);
		div_in = '0;
		div_in.vld = s_axis_tvalid;
		div_in.last = last;
		div_in.half = last >> 1;
		div_in.ring = (s_axis_tdata[7:0] > last) ? last : s_axis_tdata[7:0];
		div_in.sector = (s_axis_tdata[15:8] > last) ? last : s_axis_tdata[15:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_chain[0] <= '0;
		end else if (en) begin
			div_chain[0] <= div_in;
		end
	end

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
		uvs_div_cell #(.POS(DIV_BITS - 1 - k)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.d_i(div_chain[k]),
			.d_o(div_chain[k + 1])
		);
	end

	always_comb begin
		cor_chain[0].vld = div_chain[DIV_BITS].vld;
		cor_chain[0].ring = div_chain[DIV_BITS].ring;
		cor_chain[0].sector = div_chain[DIV_BITS].sector;
		cor_chain[0].last = div_chain[DIV_BITS].last;
		cor_chain[0].tex_u = div_chain[DIV_BITS].tex_u;
		cor_chain[0].tex_v = div_chain[DIV_BITS].tex_v;
		cor_chain[0].qdlat = quad_t'(div_chain[DIV_BITS].qlat[31:30]);
		cor_chain[0].qdlon = quad_t'(div_chain[DIV_BITS].qlon[31:30]);
		cor_chain[0].xlat = CORDIC_GAIN_Q30;
		cor_chain[0].ylat = '0;
		cor_chain[0].zlat = {3'd0, div_chain[DIV_BITS].qlat[29:0]};
		cor_chain[0].xlon = CORDIC_GAIN_Q30;
		cor_chain[0].ylon = '0;
		cor_chain[0].zlon = {3'd0, div_chain[DIV_BITS].qlon[29:0]};
	end

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cor
		uvs_cordic_cell #(.K(k)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.c_i(cor_chain[k]),
			.c_o(cor_chain[k + 1])
		);
	end

	uvs_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.c_i(cor_chain[CORDIC_STAGES]),
		.radius(radius_q),
		.vld_o(m_axis_tvalid),
		.data_o(m_axis_tdata)
	);

`ifndef SYNTH
	a_last_sector: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[136:120] == 17'h10000 |-> m_axis_tdata[217:154] == '0)
		else $error("Quad indices not zero on the last sector.");
	a_last_ring: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[153:137] == 17'h10000 |-> m_axis_tdata[217:154] == '0)
		else $error("Quad indices not zero on the last ring.");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Output item changed while it waited.");
`endif

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the UV sphere vertex generator core.
`timescale 1ns / 100ps

module tb
	import uvs_pkg::*;
();

	localparam int STAGES = 16;
	localparam int LATENCY = 46 + STAGES;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [7:0] sector;
		logic [7:0] ring;
	} grid_point_t;

	typedef struct packed {
		logic [5:0]  pad;
		logic [15:0] qd;
		logic [15:0] qc;
		logic [15:0] qb;
		logic [15:0] qa;
		logic [16:0] tv;
		logic [16:0] tu;
		logic [15:0] nz;
		logic [15:0] ny;
		logic [15:0] nx;
		logic [23:0] pz;
		logic [23:0] py;
		logic [23:0] px;
	} vertex_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [15:0]  s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [223:0] m_axis_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [0:0]   cfg_index = REG_GRID_UNITS;
	logic [15:0]  cfg_data = '0;

	grid_point_t pending_points[$];
	vertex_t     expected_vertices[$];
	logic [8:0]  units_reg = 9'd16;
	logic [15:0] radius_reg = 16'd256;
	int          errors = 0;
	int          sent = 0;
	int          seen = 0;
	int          cycles = 0;
	int          send_gap = 0;
	int          recv_stall = 0;
	int          hold_left = 0;
	bit          hold_done = 0;

	uv_sphere_vertex_generator_core uut (.*);

	always #5 clk = ~clk;

	function automatic void sin_cos(input logic [31:0] ph, output longint s, output longint c);
		longint x, y, z, dx, dy;
		x = 652032874;
		y = 0;
		z = longint'(ph[29:0]);
		for (int k = 0; k < STAGES; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_TURN[k]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_TURN[k]);
			end
		end
		case (ph[31:30])
			QUAD_0: begin c = x;  s = y;  end
			QUAD_1: begin c = -y; s = x;  end
			QUAD_2: begin c = -x; s = -y; end
			default: begin c = y;  s = -x; end
		endcase
	endfunction

	function automatic logic [15:0] normal_q14(longint n);
		longint v;
		v = (n + 32768) >>> 16;
		if (v < -16384) v = -16384;
		if (v > 16384) v = 16384;
		return v[15:0];
	endfunction

	function automatic logic [23:0] position_q14(longint n, longint r);
		longint v;
		v = (n * r + (longint'(1) << 23)) >>> 24;
		if (v < -8388608) v = -8388608;
		if (v > 8388607) v = 8388607;
		return v[23:0];
	endfunction

	function automatic vertex_t sphere_vertex(grid_point_t p);
		vertex_t v;
		longint unsigned u, d, i, j, lat, lon;
		longint sl, cl, sn, cn, nx, ny, nz;
		u = units_reg;
		if (u < 2) u = 2;
		if (u > 256) u = 256;
		d = u - 1;
		i = (p.ring > d) ? d : p.ring;
		j = (p.sector > d) ? d : p.sector;
		lat = ((i << 31) + d / 2) / d;
		lon = ((j << 32) + d / 2) / d;
		sin_cos(lat[31:0], sl, cl);
		sin_cos(lon[31:0], sn, cn);
		nx = (cn * sl + (longint'(1) << 29)) >>> 30;
		ny = -cl;
		nz = (sn * sl + (longint'(1) << 29)) >>> 30;
		v = '0;
		v.px = position_q14(nx, radius_reg);
		v.py = position_q14(ny, radius_reg);
		v.pz = position_q14(nz, radius_reg);
		v.nx = normal_q14(nx);
		v.ny = normal_q14(ny);
		v.nz = normal_q14(nz);
		v.tu = 17'(((j << 16) + d / 2) / d);
		v.tv = 17'(((i << 16) + d / 2) / d);
		if (i != d && j != d) begin
			v.qa = 16'(i * u + j);
			v.qb = 16'(i * u + j + 1);
			v.qc = 16'((i + 1) * u + j + 1);
			v.qd = 16'((i + 1) * u + j);
		end
		return v;
	endfunction

	function automatic int draw_gap();
		if ((sent / 64) % 3 == 0) return 0;
		return $urandom_range(0, 7);
	endfunction

	always @(posedge clk) begin
		logic nv;
		nv = s_axis_tvalid;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_vertices.push_back(sphere_vertex(grid_point_t'(s_axis_tdata)));
				sent++;
				nv = 1'b0;
			end
			if (!nv) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_points.size() != 0) begin
					s_axis_tdata <= pending_points.pop_front();
					nv = 1'b1;
					send_gap = draw_gap();
				end
			end
		end
		s_axis_tvalid <= nv;
	end

	function automatic void check_field(string name, logic [23:0] e, logic [23:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		vertex_t e, a;
		logic nr;
		nr = m_axis_tready;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				a = vertex_t'(m_axis_tdata);
				seen++;
				if (expected_vertices.size() == 0) begin
					$display("%0t: unexpected item, actual %h", $time, m_axis_tdata);
					errors++;
				end else begin
					e = expected_vertices.pop_front();
					check_field("pos_x", e.px, a.px);
					check_field("pos_y", e.py, a.py);
					check_field("pos_z", e.pz, a.pz);
					check_field("norm_x", 24'(e.nx), 24'(a.nx));
					check_field("norm_y", 24'(e.ny), 24'(a.ny));
					check_field("norm_z", 24'(e.nz), 24'(a.nz));
					check_field("tex_u", 24'(e.tu), 24'(a.tu));
					check_field("tex_v", 24'(e.tv), 24'(a.tv));
					check_field("quad_a", 24'(e.qa), 24'(a.qa));
					check_field("quad_b", 24'(e.qb), 24'(a.qb));
					check_field("quad_c", 24'(e.qc), 24'(a.qc));
					check_field("quad_d", 24'(e.qd), 24'(a.qd));
				end
				recv_stall = ((seen / 50) % 3 == 1) ? 0 : $urandom_range(0, 7);
				if (seen == 100 && !hold_done) begin
					hold_left = 400;
					hold_done = 1;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				nr = 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				nr = 1'b0;
			end else begin
				nr = 1'b1;
			end
		end
		m_axis_tready <= nr;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("uv_sphere_vertex_generator_core regression: fail");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_points.size() != 0 || s_axis_tvalid || expected_vertices.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_GRID_UNITS) units_reg = val[8:0];
		else radius_reg = val;
	endtask

	task automatic push_random(int n, int reach);
		grid_point_t p;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				p.ring = 8'($urandom);
				p.sector = 8'($urandom);
			end else begin
				p.ring = 8'($urandom_range(0, reach));
				p.sector = 8'($urandom_range(0, reach));
			end
			pending_points.push_back(p);
		end
	endtask

	initial begin
		static int units_set[9] = '{16, 2, 256, 0, 300, 1, 5, 33, 200};
		static int radius_set[9] = '{256, 65535, 0, 256, 1, 12345, 65535, 700, 40000};
		int reach;
		grid_point_t p;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 9; ph++) begin
			if (ph > 0) begin
				wait_drained();
				write_reg(REG_GRID_UNITS, 16'(units_set[ph]));
				write_reg(REG_RADIUS, 16'(radius_set[ph]));
			end
			reach = units_set[ph] < 2 ? 1 : (units_set[ph] > 256 ? 255 : units_set[ph] - 1);
			if (ph == 0 || ph == 2) begin
				p = '{8'd0, 8'd0};      pending_points.push_back(p);
				p = '{8'd255, 8'd255};  pending_points.push_back(p);
				p = '{8'd0, 8'd255};    pending_points.push_back(p);
				p = '{8'd255, 8'd0};    pending_points.push_back(p);
				p = '{8'd15, 8'd15};    pending_points.push_back(p);
				p = '{8'd14, 8'd14};    pending_points.push_back(p);
				p = '{8'd14, 8'd0};     pending_points.push_back(p);
				p = '{8'd4, 8'd8};      pending_points.push_back(p);
				p = '{8'hAA, 8'h55};    pending_points.push_back(p);
				p = '{8'h55, 8'hAA};    pending_points.push_back(p);
				p = '{8'd254, 8'd253};  pending_points.push_back(p);
			end
			push_random(ph == 0 ? 250 : 65, reach);
		end
		wait_drained();
		$display("Ran %0d grid points over nine grid and radius settings, checked %0d vertices.",
			sent, seen);
		$display("Settings included saturated unit counts, zero and full-scale radius.");
		if (errors == 0) begin
			$display("uv_sphere_vertex_generator_core regression: pass");
		end else begin
			$display("uv_sphere_vertex_generator_core regression: fail");
		end
		$finish;
	end

endmodule

FILE: uv_sphere_vertex_generator_core.f
rtl/core/uvs_pkg.sv
rtl/core/uvs_div_cell.sv
rtl/core/uvs_cordic_cell.sv
rtl/core/uvs_out_stage.sv
rtl/core/uv_sphere_vertex_generator_core.sv
sim/tb.sv
